// ----- src/ttv_pkg.sv -----
// Shared types and constants for the triangle tangent vector unit.
`timescale 1ns / 1ps
package ttv_pkg;

  localparam int NORM_BITS = 30;
  localparam int EDGE_W = 33;
  localparam int PROD_W = 66;
  localparam int ACC_W = 68;
  localparam int MAG_W = 67;
  localparam int SUM_W = 62;
  localparam int ROOT_W = 31;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } vtx_t;

  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic               degenerate;
  } tan_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } rd_ctrl_t;

endpackage

// ----- src/ttv_mul.sv -----
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module ttv_mul (
  input  logic                                 clk,
  input  logic signed [ttv_pkg::EDGE_W-1:0]    a,
  input  logic signed [ttv_pkg::EDGE_W-1:0]    b,
  output logic signed [ttv_pkg::PROD_W-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- src/ttv_rootdiv.sv -----
// Iterative square root and restoring divider sharing one compare-subtract step.
`timescale 1ns / 1ps
module ttv_rootdiv #(
  parameter int QW = 15,
  parameter int NW = 45
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ttv_pkg::rd_ctrl_t                 ctrl,
  input  logic [ttv_pkg::SUM_W-1:0]         radicand,
  input  logic [NW-1:0]                     num,
  input  logic [ttv_pkg::ROOT_W-1:0]        den,
  output logic                              busy,
  output logic                              done,
  output logic [ttv_pkg::ROOT_W-1:0]        res
);

  localparam int CW = 5;

  logic          is_div;
  logic [CW-1:0] cnt;
  logic [32:0]   rem;
  logic [61:0]   src;
  logic [33:0]   op_a;
  logic [33:0]   op_b;
  logic [33:0]   diff;
  logic          ge;

  always_comb begin
    if (is_div) begin
      op_a = {2'b00, rem[30:0], src[61]};
      op_b = {3'b000, den};
    end else begin
      op_a = {1'b0, rem[30:0], src[61:60]};
      op_b = {1'b0, res, 2'b01};
    end
    diff = op_a - op_b;
    ge = !diff[33];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        is_div <= ctrl.is_div;
        res <= '0;
        if (ctrl.is_div) begin
          cnt <= CW'(QW - 1);
          rem <= 33'(num >> QW);
          src <= {num[QW-1:0], {(62 - QW){1'b0}}};
        end else begin
          cnt <= CW'(30);
          rem <= '0;
          src <= radicand;
        end
      end else if (busy) begin
        rem <= ge ? diff[32:0] : op_a[32:0];
        res <= {res[29:0], ge};
        src <= is_div ? {src[60:0], 1'b0} : {src[59:0], 2'b00};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/triangle_tangent_vector_unit.sv -----
// Triangle tangent vector unit: top level with vertex store and sequencer.
`timescale 1ns / 1ps
// The first two vertices of a triangle are stored and produce no item. The third vertex
// starts the work: eight products through the shared multiplier, s one-bit normalizing
// shifts (0 to 35) and a final check, three squares, a 31-step square root and three
// divisions in the shared root and divide unit, and the output state. A degenerate
// determinant ends after the first two products. The output state waits while an earlier
// item is still held. The vertex channel is not ready while that work runs.
module triangle_tangent_vector_unit #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          vtx_valid,
  output logic          vtx_ready,
  input  ttv_pkg::vtx_t vtx,
  output logic          tan_valid,
  input  logic          tan_ready,
  output ttv_pkg::tan_t tan
);

  localparam int QW = OUT_FRAC_BITS + 1;
  localparam int NW = 31 + OUT_FRAC_BITS;
  localparam int EW = ttv_pkg::EDGE_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SHIFT, S_SQ, S_ROOT, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic [1:0] phase;
  logic [3:0] step;
  logic [1:0] k;
  logic launched;

  logic signed [31:0] p0 [3];
  logic signed [31:0] p1 [3];
  logic signed [31:0] t0 [2];
  logic signed [31:0] t1 [2];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [EW-1:0] du1, dv1, du2, dv2;

  logic signed [ttv_pkg::ACC_W-1:0] acc;
  logic det_neg;
  logic [ttv_pkg::MAG_W-1:0] mag [3];
  logic neg [3];
  logic [ttv_pkg::SUM_W-1:0] sum;
  logic [ttv_pkg::ROOT_W-1:0] len;
  logic [QW-1:0] q [3];
  logic deg;

  logic signed [EW-1:0] mul_a, mul_b;
  logic signed [ttv_pkg::PROD_W-1:0] prod;
  logic signed [ttv_pkg::ACC_W-1:0] prod_x, dif, tv;
  logic [2:0] j;
  logic [1:0] mk;
  logic [NW-1:0] num;
  ttv_pkg::rd_ctrl_t rd_ctrl;
  logic rd_busy, rd_done;
  logic [ttv_pkg::ROOT_W-1:0] rd_res;
  logic [ttv_pkg::MAG_W-1:0] mag_or;
  logic [31:0] qx [3];
  logic [31:0] qs [3];

  assign vtx_ready = (state == S_IDLE);
  assign j = step[3:1];
  assign mk = j[2:1] - 2'd1;

  always_comb begin
    mul_a = du1;
    mul_b = dv2;
    if (state == S_SQ) begin
      mul_a = EW'({1'b0, mag[step[2:1]][29:0]});
      mul_b = mul_a;
    end else begin
      case (j)
        3'd0: begin
          mul_a = du1;
          mul_b = dv2;
        end
        3'd1: begin
          mul_a = dv1;
          mul_b = du2;
        end
        default: begin
          if (j[0]) begin
            mul_a = dv1;
            mul_b = e2[mk];
          end else begin
            mul_a = dv2;
            mul_b = e1[mk];
          end
        end
      endcase
    end
    prod_x = {{2{prod[ttv_pkg::PROD_W-1]}}, prod};
    dif = acc - prod_x;
    tv = det_neg ? -dif : dif;
    mag_or = mag[0] | mag[1] | mag[2];
    num = (NW'(mag[k][29:0]) << OUT_FRAC_BITS) + NW'(len[30:1]);
    rd_ctrl.start = ((state == S_ROOT) || (state == S_DIV)) && !launched && !rd_busy;
    rd_ctrl.is_div = (state == S_DIV);
    for (int i = 0; i < 3; i++) begin
      qx[i] = 32'(q[i]);
      qs[i] = neg[i] ? -qx[i] : qx[i];
    end
  end

  ttv_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  ttv_rootdiv #(
    .QW (QW),
    .NW (NW)
  ) u_rootdiv (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (rd_ctrl),
    .radicand (sum),
    .num      (num),
    .den      (len),
    .busy     (rd_busy),
    .done     (rd_done),
    .res      (rd_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 2'd0;
      launched <= 1'b0;
      tan_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        p0[i] <= '0;
        p1[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        t0[i] <= '0;
        t1[i] <= '0;
      end
    end else begin
      if (tan_valid && tan_ready && (state != S_OUT)) begin
        tan_valid <= 1'b0;
      end
      if (rd_ctrl.start) begin
        launched <= 1'b1;
      end else if (rd_done) begin
        launched <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (vtx_valid) begin
            if (phase == 2'd1) begin
              p1[0] <= vtx.pos_x;
              p1[1] <= vtx.pos_y;
              p1[2] <= vtx.pos_z;
              t1[0] <= vtx.tex_u;
              t1[1] <= vtx.tex_v;
              phase <= 2'd2;
            end else if (phase == 2'd2) begin
              for (int i = 0; i < 3; i++) begin
                e1[i] <= EW'(p1[i]) - EW'(p0[i]);
              end
              e2[0] <= EW'(vtx.pos_x) - EW'(p0[0]);
              e2[1] <= EW'(vtx.pos_y) - EW'(p0[1]);
              e2[2] <= EW'(vtx.pos_z) - EW'(p0[2]);
              du1 <= EW'(t1[0]) - EW'(t0[0]);
              dv1 <= EW'(t1[1]) - EW'(t0[1]);
              du2 <= EW'(vtx.tex_u) - EW'(t0[0]);
              dv2 <= EW'(vtx.tex_v) - EW'(t0[1]);
              phase <= 2'd0;
              step <= '0;
              deg <= 1'b0;
              state <= S_MUL;
            end else begin
              p0[0] <= vtx.pos_x;
              p0[1] <= vtx.pos_y;
              p0[2] <= vtx.pos_z;
              t0[0] <= vtx.tex_u;
              t0[1] <= vtx.tex_v;
              phase <= 2'd1;
            end
          end
        end
        S_MUL: begin
          step <= step + 1'b1;
          if (step[0]) begin
            if (!j[0]) begin
              acc <= prod_x;
            end else if (j == 3'd1) begin
              det_neg <= dif[ttv_pkg::ACC_W-1];
              if (dif == '0) begin
                deg <= 1'b1;
                state <= S_OUT;
              end
            end else begin
              neg[mk] <= tv[ttv_pkg::ACC_W-1];
              mag[mk] <= tv[ttv_pkg::ACC_W-1] ? ttv_pkg::MAG_W'(-tv)
                                              : tv[ttv_pkg::MAG_W-1:0];
              if (j == 3'd7) begin
                state <= S_SHIFT;
              end
            end
          end
        end
        S_SHIFT: begin
          if (mag_or == '0) begin
            deg <= 1'b1;
            state <= S_OUT;
          end else if (mag_or[ttv_pkg::MAG_W-1:ttv_pkg::NORM_BITS] != '0) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else begin
            step <= '0;
            sum <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          step <= step + 1'b1;
          if (step[0]) begin
            sum <= sum + prod[ttv_pkg::SUM_W-1:0];
            if (step[2:1] == 2'd2) begin
              state <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          if (rd_done) begin
            len <= rd_res;
            k <= 2'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rd_done) begin
            q[k] <= rd_res[QW-1:0];
            k <= k + 1'b1;
            if (k == 2'd2) begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!tan_valid || tan_ready) begin
            tan_valid <= 1'b1;
            tan.degenerate <= deg;
            tan.tangent_x <= deg ? '0 : qs[0][15:0];
            tan.tangent_y <= deg ? '0 : qs[1][15:0];
            tan.tangent_z <= deg ? '0 : qs[2][15:0];
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_third_vertex_starts: assert property (@(posedge clk) disable iff (rst)
    (vtx_valid && vtx_ready && phase == 2'd2) |=> (state == S_MUL))
    else $error("third vertex did not start the tangent computation");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (tan_valid && tan.degenerate) |->
      (tan.tangent_x == '0 && tan.tangent_y == '0 && tan.tangent_z == '0))
    else $error("degenerate item carries a nonzero tangent");

  a_unit_busy_state: assert property (@(posedge clk) disable iff (rst)
    rd_busy |-> (state == S_ROOT || state == S_DIV))
    else $error("root and divide unit busy outside its states");

endmodule
